>>> rtl/wss_pkg.sv
// Shared constants and types of the windowed sensor statistics block.
package wss_pkg;

  localparam int unsigned NUM_CH            = 8;
  localparam int unsigned SAMPLE_W          = 16;
  localparam int unsigned BLOCK_LEN_DEF     = 12;
  localparam int unsigned HISTORY_DEPTH_DEF = 12;

  typedef enum logic [1:0] {
    MODE_OFF = 2'd0,
    MODE_AVG = 2'd1,
    MODE_MIN = 2'd2,
    MODE_MAX = 2'd3
  } disp_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DRAIN,
    ST_WRITE,
    ST_SCAN,
    ST_TAIL,
    ST_EMIT
  } wss_state_e;

  typedef struct packed {
    logic in_ready;
    logic div_issue;
    logic mem_we;
    logic rd_en;
    logic out_load;
  } wss_ctrl_t;

endpackage

>>> rtl/wss_sample_if.sv
// Input channel: one item carries one sample per sensor channel.
interface wss_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [wss_pkg::SAMPLE_W-1:0] latitude;
  logic signed [wss_pkg::SAMPLE_W-1:0] longitude;
  logic signed [wss_pkg::SAMPLE_W-1:0] altitude;
  logic signed [wss_pkg::SAMPLE_W-1:0] temperature;
  logic signed [wss_pkg::SAMPLE_W-1:0] humidity;
  logic signed [wss_pkg::SAMPLE_W-1:0] wind_speed;
  logic signed [wss_pkg::SAMPLE_W-1:0] wind_direction;
  logic signed [wss_pkg::SAMPLE_W-1:0] rainfall;

  modport source (
    output valid, latitude, longitude, altitude, temperature, humidity,
           wind_speed, wind_direction, rainfall,
    input  ready
  );

  modport sink (
    input  valid, latitude, longitude, altitude, temperature, humidity,
           wind_speed, wind_direction, rainfall,
    output ready
  );
endinterface

>>> rtl/wss_stat_if.sv
// Output channel: one item carries the selected statistic of every channel.
interface wss_stat_if;
  logic                                valid;
  logic                                ready;
  logic signed [wss_pkg::SAMPLE_W-1:0] out_latitude;
  logic signed [wss_pkg::SAMPLE_W-1:0] out_longitude;
  logic signed [wss_pkg::SAMPLE_W-1:0] out_altitude;
  logic signed [wss_pkg::SAMPLE_W-1:0] out_temperature;
  logic signed [wss_pkg::SAMPLE_W-1:0] out_humidity;
  logic signed [wss_pkg::SAMPLE_W-1:0] out_wind_speed;
  logic signed [wss_pkg::SAMPLE_W-1:0] out_wind_direction;
  logic signed [wss_pkg::SAMPLE_W-1:0] out_rainfall;

  modport source (
    output valid, out_latitude, out_longitude, out_altitude, out_temperature,
           out_humidity, out_wind_speed, out_wind_direction, out_rainfall,
    input  ready
  );

  modport sink (
    input  valid, out_latitude, out_longitude, out_altitude, out_temperature,
           out_humidity, out_wind_speed, out_wind_direction, out_rainfall,
    output ready
  );
endinterface

>>> rtl/windowed_sensor_statistics.sv
// Top level: block averages per sensor channel with min/max over a history memory.
//
// Each item adds its eight samples into per-channel sums.
// The item that completes a block of BLOCK_LEN starts a pass during which no
// item is taken: a shared reciprocal divider forms one channel average per
// cycle, the averages are written as one row of the history memory, and the
// memory is read back one row per cycle through its single read port to find
// minimum and maximum. The result then goes to an output register, so the next
// item is taken while it waits; the pass after that stalls in its last cycle
// until the register is free. Rows never written read as zero through per-row
// valid bits.
module windowed_sensor_statistics #(
  parameter int unsigned BLOCK_LEN     = wss_pkg::BLOCK_LEN_DEF,
  parameter int unsigned HISTORY_DEPTH = wss_pkg::HISTORY_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  wss_sample_if.sink        sample_i,
  wss_stat_if.source        stat_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_wdata_i
);

  localparam int unsigned NCH   = wss_pkg::NUM_CH;
  localparam int unsigned SW    = wss_pkg::SAMPLE_W;
  localparam int unsigned CNT_W = $clog2(BLOCK_LEN);
  localparam int unsigned HP_W  = $clog2(HISTORY_DEPTH);
  localparam int unsigned CH_W  = $clog2(NCH);
  localparam int unsigned SUM_W = SW + CNT_W;

  localparam logic [SUM_W-1:0] RECIP    = SUM_W'((64'd1 << SUM_W) / 64'(BLOCK_LEN));
  localparam logic [SUM_W-1:0] BLK      = SUM_W'(BLOCK_LEN);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BLOCK_LEN - 1);
  localparam logic [HP_W-1:0]  HP_LAST  = HP_W'(HISTORY_DEPTH - 1);
  localparam logic [CH_W-1:0]  CH_LAST  = CH_W'(NCH - 1);

  wss_pkg::wss_state_e state_q, state_d;
  wss_pkg::wss_ctrl_t  ctrl;
  wss_pkg::disp_mode_e mode_q;

  logic                        in_acc;
  logic [NCH-1:0][SW-1:0]      samp;
  logic [NCH-1:0][SUM_W-1:0]   sums_q;
  logic [CNT_W-1:0]            cnt_q;
  logic [HP_W-1:0]             hp_q;
  logic [CH_W-1:0]             ch_q;
  logic [HP_W-1:0]             scan_q;

  // divider pipeline
  logic                        a_vld_q, b_vld_q;
  logic [CH_W-1:0]             a_ch_q, b_ch_q;
  logic                        a_neg_q, b_neg_q;
  logic [SUM_W-1:0]            a_mag_q, b_mag_q, q0_q;
  logic [SUM_W-1:0]            sel_sum, a_mag_d;
  logic [2*SUM_W-1:0]          prod_b, prod_c;
  logic [SUM_W-1:0]            rem_c, q1_c, qs_c;
  logic [NCH-1:0][SW-1:0]      avg_q;

  // history memory and scan
  logic [NCH-1:0][SW-1:0]      hist_mem [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0]    row_vld_q;
  logic [NCH-1:0][SW-1:0]      rd_data_q;
  logic                        rd_vld_q, rd_first_q, rd_row_vld_q;
  logic [NCH-1:0][SW-1:0]      lo_q, hi_q, lo_d, hi_d, elem;

  logic                        out_vld_q;
  logic [NCH-1:0][SW-1:0]      out_q, out_d;

  assign samp[0] = sample_i.latitude;
  assign samp[1] = sample_i.longitude;
  assign samp[2] = sample_i.altitude;
  assign samp[3] = sample_i.temperature;
  assign samp[4] = sample_i.humidity;
  assign samp[5] = sample_i.wind_speed;
  assign samp[6] = sample_i.wind_direction;
  assign samp[7] = sample_i.rainfall;

  assign sample_i.ready = ctrl.in_ready;
  assign in_acc         = sample_i.valid && ctrl.in_ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wss_pkg::ST_IDLE: begin
        if (in_acc && cnt_q == CNT_LAST) state_d = wss_pkg::ST_DIV;
      end
      wss_pkg::ST_DIV: begin
        if (ch_q == CH_LAST) state_d = wss_pkg::ST_DRAIN;
      end
      wss_pkg::ST_DRAIN: begin
        if (b_vld_q && b_ch_q == CH_LAST) state_d = wss_pkg::ST_WRITE;
      end
      wss_pkg::ST_WRITE: begin
        state_d = wss_pkg::ST_SCAN;
      end
      wss_pkg::ST_SCAN: begin
        if (scan_q == HP_LAST) state_d = wss_pkg::ST_TAIL;
      end
      wss_pkg::ST_TAIL: begin
        state_d = wss_pkg::ST_EMIT;
      end
      wss_pkg::ST_EMIT: begin
        if (!out_vld_q || stat_o.ready) state_d = wss_pkg::ST_IDLE;
      end
      default: state_d = wss_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.in_ready  = (state_q == wss_pkg::ST_IDLE);
    ctrl.div_issue = (state_q == wss_pkg::ST_DIV);
    ctrl.mem_we    = (state_q == wss_pkg::ST_WRITE);
    ctrl.rd_en     = (state_q == wss_pkg::ST_SCAN);
    ctrl.out_load  = (state_q == wss_pkg::ST_EMIT) && (!out_vld_q || stat_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wss_pkg::ST_IDLE;
      mode_q  <= wss_pkg::MODE_OFF;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) mode_q <= wss_pkg::disp_mode_e'(cfg_wdata_i);
    end
  end

  // sums and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sums_q <= '0;
      cnt_q  <= '0;
      hp_q   <= '0;
      ch_q   <= '0;
      scan_q <= '0;
    end else begin
      if (in_acc) begin
        for (int c = 0; c < NCH; c++) begin
          sums_q[c] <= sums_q[c] + {{CNT_W{samp[c][SW-1]}}, samp[c]};
        end
        cnt_q <= (cnt_q == CNT_LAST) ? '0 : cnt_q + 1'b1;
      end
      if (ctrl.mem_we) begin
        sums_q <= '0;
        hp_q   <= (hp_q == HP_LAST) ? '0 : hp_q + 1'b1;
      end
      if (ctrl.div_issue) ch_q <= ch_q + 1'b1;
      else                ch_q <= '0;
      if (ctrl.rd_en) scan_q <= (scan_q == HP_LAST) ? '0 : scan_q + 1'b1;
      else            scan_q <= '0;
    end
  end

  // divide by BLOCK_LEN: sign/magnitude, reciprocal multiply, one-step correction
  always_comb begin
    sel_sum = sums_q[ch_q];
    a_mag_d = sel_sum[SUM_W-1] ? (~sel_sum + 1'b1) : sel_sum;
    prod_b  = a_mag_q * RECIP;
    prod_c  = q0_q * BLK;
    rem_c   = b_mag_q - prod_c[SUM_W-1:0];
    q1_c    = (rem_c >= BLK) ? q0_q + 1'b1 : q0_q;
    qs_c    = b_neg_q ? (~q1_c + 1'b1) : q1_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      a_vld_q <= ctrl.div_issue;
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_ch_q  <= ch_q;
    a_neg_q <= sel_sum[SUM_W-1];
    a_mag_q <= a_mag_d;
    b_ch_q  <= a_ch_q;
    b_neg_q <= a_neg_q;
    b_mag_q <= a_mag_q;
    q0_q    <= prod_b[2*SUM_W-1:SUM_W];
    if (b_vld_q) avg_q[b_ch_q] <= qs_c[SW-1:0];
  end

  // history memory, one row of all channels per block
  always_ff @(posedge clk_i) begin
    if (ctrl.mem_we) hist_mem[hp_q] <= avg_q;
    if (ctrl.rd_en)  rd_data_q <= hist_mem[scan_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q    <= '0;
      rd_vld_q     <= 1'b0;
      rd_first_q   <= 1'b0;
      rd_row_vld_q <= 1'b0;
    end else begin
      if (ctrl.mem_we) row_vld_q[hp_q] <= 1'b1;
      rd_vld_q     <= ctrl.rd_en;
      rd_first_q   <= (scan_q == '0);
      rd_row_vld_q <= row_vld_q[scan_q];
    end
  end

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      elem[c] = rd_row_vld_q ? rd_data_q[c] : '0;
      lo_d[c] = lo_q[c];
      hi_d[c] = hi_q[c];
      if (rd_first_q) begin
        lo_d[c] = elem[c];
        hi_d[c] = elem[c];
      end else begin
        if ($signed(elem[c]) < $signed(lo_q[c])) lo_d[c] = elem[c];
        if ($signed(elem[c]) > $signed(hi_q[c])) hi_d[c] = elem[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  // output register
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      unique case (mode_q)
        wss_pkg::MODE_OFF: out_d[c] = '0;
        wss_pkg::MODE_AVG: out_d[c] = avg_q[c];
        wss_pkg::MODE_MIN: out_d[c] = lo_q[c];
        wss_pkg::MODE_MAX: out_d[c] = hi_q[c];
        default:           out_d[c] = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_vld_q <= 1'b1;
    end else if (stat_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) out_q <= out_d;
  end

  assign stat_o.valid              = out_vld_q;
  assign stat_o.out_latitude       = out_q[0];
  assign stat_o.out_longitude      = out_q[1];
  assign stat_o.out_altitude       = out_q[2];
  assign stat_o.out_temperature    = out_q[3];
  assign stat_o.out_humidity       = out_q[4];
  assign stat_o.out_wind_speed     = out_q[5];
  assign stat_o.out_wind_direction = out_q[6];
  assign stat_o.out_rainfall       = out_q[7];

  a_block_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && cnt_q == CNT_LAST) |=> (state_q == wss_pkg::ST_DIV))
    else $error("block end did not start the average pass");

  a_sums_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wss_pkg::ST_WRITE) |=> (sums_q == '0))
    else $error("sums not cleared after history write");

  a_write_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wss_pkg::ST_WRITE) |-> $past(b_vld_q && b_ch_q == CH_LAST))
    else $error("history row written before all averages were ready");

  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> ($past(state_q) == wss_pkg::ST_EMIT))
    else $error("result item raised outside the emit step");

endmodule
